>>> sv/afi_pkg.sv
// Shared types and constants for the affine matrix inverse block.
// Used by every module of the block; depends on nothing else.
package afi_pkg;

   localparam int EW = 32;                  // entry width
   localparam int FB = 16;                  // fraction bits
   localparam int ADJ_W = 2 * EW + 1;       // 2x2 cofactor width
   localparam int DW = 3 * EW + 3;          // determinant and translation sum width
   localparam int NW = DW + 2 * FB;         // dividend magnitude width
   localparam int QW = EW + 1;              // quotient bits kept before saturation
   localparam int CW = NW + QW;             // divider compare width
   localparam int LANES = 4;
   localparam int TRANS_LANE = 3;
   localparam int LANE_LAT = QW + 2;        // divider lane latency in cycles

   localparam logic [1:0] ROW0 = 2'd0;
   localparam logic [1:0] ROW1 = 2'd1;
   localparam logic [1:0] ROW2 = 2'd2;

   localparam logic [EW-1:0] ENTRY_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] ENTRY_MIN = {1'b1, {(EW-1){1'b0}}};
   localparam logic ONE_CLIPS = (FB >= EW - 1);
   localparam logic [EW-1:0] ONE_VAL = ONE_CLIPS ? ENTRY_MAX : (EW'(1) << FB);

   typedef struct packed {
      logic signed [EW-1:0] row0_col0;
      logic signed [EW-1:0] row0_col1;
      logic signed [EW-1:0] row0_col2;
      logic signed [EW-1:0] row0_col3;
      logic signed [EW-1:0] row1_col0;
      logic signed [EW-1:0] row1_col1;
      logic signed [EW-1:0] row1_col2;
      logic signed [EW-1:0] row1_col3;
      logic signed [EW-1:0] row2_col0;
      logic signed [EW-1:0] row2_col1;
      logic signed [EW-1:0] row2_col2;
      logic signed [EW-1:0] row2_col3;
   } afi_req_type;

   typedef struct packed {
      logic [1:0]           out_row;
      logic signed [EW-1:0] out_col0;
      logic signed [EW-1:0] out_col1;
      logic signed [EW-1:0] out_col2;
      logic signed [EW-1:0] out_col3;
      logic                 singular;
      logic                 clipped;
      logic                 last_row;
   } afi_rsp_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] row;
      logic       singular;
   } afi_meta_type;

   typedef struct packed {
      logic [NW-1:0] num;
      logic [DW-1:0] den;
      logic          neg;
   } afi_div_in_type;

   typedef struct packed {
      logic [EW-1:0] value;
      logic          clip;
   } afi_div_out_type;

endpackage

>>> sv/afi_front.sv
// Request holding register, row sequencer and the cofactor, determinant and
// translation-sum pipeline that feeds the divider lanes. Depends on afi_pkg.
module afi_front (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         adv,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  afi_pkg::afi_req_type                         req_data,
   output afi_pkg::afi_meta_type                        meta,
   output afi_pkg::afi_div_in_type [afi_pkg::LANES-1:0] div_in
);
   import afi_pkg::*;

   afi_req_type item_ff;
   logic        held_ff, held_in;
   logic [1:0]  row_ff, row_in;
   logic        accept;

   logic signed [EW-1:0] x1 [3];
   logic signed [EW-1:0] x2 [3];
   logic signed [EW-1:0] tcol [3];
   logic signed [EW-1:0] acol [3];

   afi_meta_type s1_meta_ff, s2_meta_ff, s3_meta_ff, s4_meta_ff, s5_meta_ff, s6_meta_ff;

   logic signed [2*EW-1:0]  s1_p_ff [3];
   logic signed [2*EW-1:0]  s1_q_ff [3];
   logic signed [EW-1:0]    s1_t_ff [3];
   logic signed [EW-1:0]    s1_a_ff [3];
   logic signed [ADJ_W-1:0] s2_adj_ff [3];
   logic signed [EW-1:0]    s2_t_ff [3];
   logic signed [EW-1:0]    s2_a_ff [3];
   logic signed [2*EW:0]    s3_ht_ff [3];
   logic signed [2*EW:0]    s3_lt_ff [3];
   logic signed [2*EW:0]    s3_ha_ff [3];
   logic signed [2*EW:0]    s3_la_ff [3];
   logic signed [ADJ_W-1:0] s3_adj_ff [3];
   logic signed [DW-1:0]    s4_pt_ff [3];
   logic signed [DW-1:0]    s4_pa_ff [3];
   logic signed [ADJ_W-1:0] s4_adj_ff [3];
   logic signed [DW-1:0]    s5_sum_ff;
   logic signed [DW-1:0]    s5_dcand_ff;
   logic signed [ADJ_W-1:0] s5_adj_ff [3];
   logic signed [DW-1:0]    det_hold_ff, det_hold_in;

   logic signed [DW-1:0]    det_sel;
   logic                    det_neg;
   logic [DW-1:0]           det_mag;
   logic [DW-1:0]           sum_mag;
   logic                    sum_neg;
   logic [ADJ_W-1:0]        adj_mag [3];
   afi_div_in_type [LANES-1:0] div_in_in;
   afi_div_in_type [LANES-1:0] div_ff;

   // A new request is taken when nothing is held or the last row leaves now.
   assign req_stall = held_ff && !(adv && (row_ff == ROW2));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      held_in = held_ff;
      row_in  = row_ff;
      if (accept) begin
         held_in = 1'b1;
         row_in  = ROW0;
      end else if (adv && held_ff) begin
         if (row_ff == ROW2) begin
            held_in = 1'b0;
            row_in  = ROW0;
         end else begin
            row_in = row_ff + 2'd1;
         end
      end
   end

   // Columns (r+1)%3 and (r+2)%3 of each matrix row for the row being issued.
   always_comb begin
      case (row_ff)
         ROW1: begin
            x1[0] = item_ff.row0_col2; x2[0] = item_ff.row0_col0;
            x1[1] = item_ff.row1_col2; x2[1] = item_ff.row1_col0;
            x1[2] = item_ff.row2_col2; x2[2] = item_ff.row2_col0;
         end
         ROW2: begin
            x1[0] = item_ff.row0_col0; x2[0] = item_ff.row0_col1;
            x1[1] = item_ff.row1_col0; x2[1] = item_ff.row1_col1;
            x1[2] = item_ff.row2_col0; x2[2] = item_ff.row2_col1;
         end
         default: begin
            x1[0] = item_ff.row0_col1; x2[0] = item_ff.row0_col2;
            x1[1] = item_ff.row1_col1; x2[1] = item_ff.row1_col2;
            x1[2] = item_ff.row2_col1; x2[2] = item_ff.row2_col2;
         end
      endcase
      tcol[0] = item_ff.row0_col3;
      tcol[1] = item_ff.row1_col3;
      tcol[2] = item_ff.row2_col3;
      acol[0] = item_ff.row0_col0;
      acol[1] = item_ff.row1_col0;
      acol[2] = item_ff.row2_col0;
   end

   // The determinant comes from row 0's cofactors and is held for rows 1 and 2.
   always_comb begin
      det_sel     = (s5_meta_ff.row == ROW0) ? s5_dcand_ff : det_hold_ff;
      det_hold_in = det_sel;
      det_neg     = det_sel[DW-1];
      det_mag     = det_neg ? DW'(-det_sel) : DW'(det_sel);
      sum_neg     = s5_sum_ff[DW-1];
      sum_mag     = sum_neg ? DW'(-s5_sum_ff) : DW'(s5_sum_ff);
      for (int c = 0; c < 3; c++) begin
         adj_mag[c]      = s5_adj_ff[c][ADJ_W-1] ? ADJ_W'(-s5_adj_ff[c]) : ADJ_W'(s5_adj_ff[c]);
         div_in_in[c].num = NW'(adj_mag[c]) << (2 * FB);
         div_in_in[c].den = det_mag;
         div_in_in[c].neg = s5_adj_ff[c][ADJ_W-1] ^ det_neg;
      end
      // The translation entry divides minus the sum, so a positive sum is negative.
      div_in_in[TRANS_LANE].num = NW'(sum_mag) << FB;
      div_in_in[TRANS_LANE].den = det_mag;
      div_in_in[TRANS_LANE].neg = (!sum_neg && (s5_sum_ff != '0)) ^ det_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff          <= 1'b0;
         row_ff           <= ROW0;
         s1_meta_ff.valid <= 1'b0;
         s2_meta_ff.valid <= 1'b0;
         s3_meta_ff.valid <= 1'b0;
         s4_meta_ff.valid <= 1'b0;
         s5_meta_ff.valid <= 1'b0;
         s6_meta_ff.valid <= 1'b0;
      end else begin
         held_ff <= held_in;
         row_ff  <= row_in;
         if (adv) begin
            s1_meta_ff.valid    <= held_ff;
            s2_meta_ff.valid    <= s1_meta_ff.valid;
            s3_meta_ff.valid    <= s2_meta_ff.valid;
            s4_meta_ff.valid    <= s3_meta_ff.valid;
            s5_meta_ff.valid    <= s4_meta_ff.valid;
            s6_meta_ff.valid    <= s5_meta_ff.valid;
            s1_meta_ff.row      <= row_ff;
            s1_meta_ff.singular <= 1'b0;
            s2_meta_ff.row      <= s1_meta_ff.row;
            s2_meta_ff.singular <= 1'b0;
            s3_meta_ff.row      <= s2_meta_ff.row;
            s3_meta_ff.singular <= 1'b0;
            s4_meta_ff.row      <= s3_meta_ff.row;
            s4_meta_ff.singular <= 1'b0;
            s5_meta_ff.row      <= s4_meta_ff.row;
            s5_meta_ff.singular <= 1'b0;
            s6_meta_ff.row      <= s5_meta_ff.row;
            s6_meta_ff.singular <= (det_sel == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            s1_p_ff[c]   <= x1[(c + 1) % 3] * x2[(c + 2) % 3];
            s1_q_ff[c]   <= x2[(c + 1) % 3] * x1[(c + 2) % 3];
            s1_t_ff[c]   <= tcol[c];
            s1_a_ff[c]   <= acol[c];
            s2_adj_ff[c] <= ADJ_W'(s1_p_ff[c]) - ADJ_W'(s1_q_ff[c]);
            s2_t_ff[c]   <= s1_t_ff[c];
            s2_a_ff[c]   <= s1_a_ff[c];
            s3_lt_ff[c]  <= $signed({1'b0, s2_adj_ff[c][EW-1:0]}) * s2_t_ff[c];
            s3_ht_ff[c]  <= $signed(s2_adj_ff[c][ADJ_W-1:EW]) * s2_t_ff[c];
            s3_la_ff[c]  <= $signed({1'b0, s2_adj_ff[c][EW-1:0]}) * s2_a_ff[c];
            s3_ha_ff[c]  <= $signed(s2_adj_ff[c][ADJ_W-1:EW]) * s2_a_ff[c];
            s3_adj_ff[c] <= s2_adj_ff[c];
            s4_pt_ff[c]  <= (DW'(s3_ht_ff[c]) <<< EW) + DW'(s3_lt_ff[c]);
            s4_pa_ff[c]  <= (DW'(s3_ha_ff[c]) <<< EW) + DW'(s3_la_ff[c]);
            s4_adj_ff[c] <= s3_adj_ff[c];
            s5_adj_ff[c] <= s4_adj_ff[c];
         end
         s5_sum_ff   <= s4_pt_ff[0] + s4_pt_ff[1] + s4_pt_ff[2];
         s5_dcand_ff <= s4_pa_ff[0] + s4_pa_ff[1] + s4_pa_ff[2];
         if (s5_meta_ff.valid && (s5_meta_ff.row == ROW0)) begin
            det_hold_ff <= det_hold_in;
         end
         div_ff <= div_in_in;
      end
   end

   assign meta   = s6_meta_ff;
   assign div_in = div_ff;

endmodule

>>> sv/afi_div_lane.sv
// One divider lane: an overflow check stage, then a restoring divider with one
// quotient bit per pipeline stage, and saturation to the entry width. Depends on afi_pkg.
module afi_div_lane (
   input  logic                     clock,
   input  logic                     adv,
   input  afi_pkg::afi_div_in_type  din,
   output afi_pkg::afi_div_out_type dout
);
   import afi_pkg::*;

   localparam int STAGES = QW + 1;
   localparam logic [QW-1:0] POS_LIMIT = {2'b00, {(EW-1){1'b1}}};
   localparam logic [QW-1:0] NEG_LIMIT = {2'b01, {(EW-1){1'b0}}};

   logic [NW-1:0] rem_ff [STAGES];
   logic [DW-1:0] den_ff [STAGES];
   logic [QW-1:0] q_ff   [STAGES];
   logic          big_ff [STAGES];
   logic          neg_ff [STAGES];

   afi_div_out_type dout_ff, dout_in;
   logic [QW-1:0]   q_fin;
   logic [QW-1:0]   q_neg;
   logic            clip_pos, clip_neg;

   genvar s;
   generate
      for (s = 0; s < STAGES; s++) begin : g_stage
         if (s == 0) begin : g_ovf
            // Quotients of 2^QW or more saturate whatever the sign.
            always_ff @(posedge clock) begin
               if (adv) begin
                  rem_ff[0] <= din.num;
                  den_ff[0] <= din.den;
                  q_ff[0]   <= '0;
                  neg_ff[0] <= din.neg;
                  big_ff[0] <= CW'(din.num) >= (CW'(din.den) << QW);
               end
            end
         end else begin : g_bit
            logic [CW-1:0] sub_val;
            logic          take;
            always_comb begin
               sub_val = CW'(den_ff[s-1]) << (QW - s);
               take    = CW'(rem_ff[s-1]) >= sub_val;
            end
            always_ff @(posedge clock) begin
               if (adv) begin
                  rem_ff[s] <= take ? NW'(CW'(rem_ff[s-1]) - sub_val) : rem_ff[s-1];
                  q_ff[s]   <= q_ff[s-1] | (QW'(take) << (QW - s));
                  den_ff[s] <= den_ff[s-1];
                  neg_ff[s] <= neg_ff[s-1];
                  big_ff[s] <= big_ff[s-1];
               end
            end
         end
      end
   endgenerate

   always_comb begin
      q_fin    = q_ff[STAGES-1];
      q_neg    = -q_fin;
      clip_pos = big_ff[STAGES-1] || (q_fin > POS_LIMIT);
      clip_neg = big_ff[STAGES-1] || (q_fin > NEG_LIMIT);
      if (neg_ff[STAGES-1]) begin
         dout_in.value = clip_neg ? ENTRY_MIN : q_neg[EW-1:0];
         dout_in.clip  = clip_neg;
      end else begin
         dout_in.value = clip_pos ? ENTRY_MAX : q_fin[EW-1:0];
         dout_in.clip  = clip_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

>>> sv/afi_merge.sv
// Merge stage: joins the four lane results of one row, substitutes the
// identity row for a singular matrix and holds the response. Depends on afi_pkg.
module afi_merge (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          rsp_stall,
   input  afi_pkg::afi_meta_type                         meta,
   input  afi_pkg::afi_div_out_type [afi_pkg::LANES-1:0] lanes,
   output logic                                          adv,
   output logic                                          rsp_valid,
   output afi_pkg::afi_rsp_type                          rsp_data
);
   import afi_pkg::*;

   logic        valid_ff;
   afi_rsp_type rsp_ff, rsp_in;

   assign adv = !valid_ff || !rsp_stall;

   always_comb begin
      rsp_in.out_row  = meta.row;
      rsp_in.last_row = (meta.row == ROW2);
      rsp_in.singular = meta.singular;
      if (meta.singular) begin
         rsp_in.out_col0 = (meta.row == ROW0) ? ONE_VAL : '0;
         rsp_in.out_col1 = (meta.row == ROW1) ? ONE_VAL : '0;
         rsp_in.out_col2 = (meta.row == ROW2) ? ONE_VAL : '0;
         rsp_in.out_col3 = '0;
         rsp_in.clipped  = ONE_CLIPS;
      end else begin
         rsp_in.out_col0 = lanes[0].value;
         rsp_in.out_col1 = lanes[1].value;
         rsp_in.out_col2 = lanes[2].value;
         rsp_in.out_col3 = lanes[TRANS_LANE].value;
         rsp_in.clipped  = lanes[0].clip || lanes[1].clip || lanes[2].clip ||
                           lanes[TRANS_LANE].clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= meta.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/affine_matrix_inverse_top.sv
// Top level of the affine 4x4 matrix inverse: front pipeline, four divider
// lanes and the merge stage. Depends on afi_pkg, afi_front, afi_div_lane, afi_merge.
//
//   channel   direction  handshake             payload
//   request   in         req_valid/req_stall   req_data (three rows of the transform)
//   response  out        rsp_valid/rsp_stall   rsp_data (one row of the inverse)
//
// Each request yields three responses, rows 0, 1 and 2 in order, issued one
// row per cycle while the response is not stalled, through four divider
// lanes (three matrix columns and the translation column).
// A new request is taken as the last row of the previous one issues. The
// divider lanes, one quotient bit per stage, make up most of the latency.
// Reset is synchronous and clears only valid and control state.
// A stalled response freezes the whole pipeline; the held request register
// still takes a new request while earlier rows are in flight.
module affine_matrix_inverse_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  afi_pkg::afi_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output afi_pkg::afi_rsp_type rsp_data
);
   import afi_pkg::*;

   logic                        adv;
   afi_meta_type                front_meta;
   afi_div_in_type  [LANES-1:0] div_in;
   afi_div_out_type [LANES-1:0] div_out;
   afi_meta_type                meta_line_ff [LANE_LAT];

   afi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .meta      (front_meta),
      .div_in    (div_in)
   );

   // One divider per output column; all lanes advance together.
   genvar g;
   generate
      for (g = 0; g < LANES; g++) begin : g_lane
         afi_div_lane u_lane (
            .clock (clock),
            .adv   (adv),
            .din   (div_in[g]),
            .dout  (div_out[g])
         );
      end
   endgenerate

   // Row tags travel beside the lanes with the same latency.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            meta_line_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         meta_line_ff[0] <= front_meta;
         for (int i = 1; i < LANE_LAT; i++) begin
            meta_line_ff[i] <= meta_line_ff[i-1];
         end
      end
   end

   afi_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .rsp_stall (rsp_stall),
      .meta      (meta_line_ff[LANE_LAT-1]),
      .lanes     (div_out),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A response never carries a row number outside the three inverse rows.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_row == ROW0 || rsp_data.out_row == ROW1 ||
                     rsp_data.out_row == ROW2))
      else $error("response row out of range");

   // Identity rows carry no translation and clip only when 1.0 does not fit.
   a_singular_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |->
         (rsp_data.out_col3 == '0 && rsp_data.clipped == ONE_CLIPS))
      else $error("singular response is not an identity row");

   // The last-row flag follows the row number.
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (rsp_data.out_row == ROW2)))
      else $error("last_row flag disagrees with row number");

   // A frozen pipeline only happens behind a waiting response.
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |-> (rsp_valid && rsp_stall))
      else $error("pipeline frozen without a stalled response");

endmodule

>>> tb/sv/afi_inverse_checker.sv
`timescale 1ns / 100ps
// Checker for the affine matrix inverse: watches both channels, predicts the
// three inverse rows of each request and compares them. Depends on afi_pkg.
module afi_inverse_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  afi_pkg::afi_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  afi_pkg::afi_rsp_type rsp_data,
   output int                   fail_count,
   output int                   rows_pending
);
   import afi_pkg::*;

   typedef logic signed [191:0] wide_int;

   afi_rsp_type expected_rows[$];

   assign rows_pending = expected_rows.size();

   // Magnitude division rounded toward zero, then saturation to the entry range.
   function automatic logic [EW-1:0] scaled_quotient(input wide_int num, input wide_int den,
                                                     inout logic clip);
      logic          neg;
      logic [191:0]  mag;
      logic [191:0]  emax;
      neg = (num < 0) != (den < 0);
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      mag = 192'(num) / 192'(den);
      emax = 192'(ENTRY_MAX);
      if (!neg) begin
         if (mag > emax) begin
            clip = 1'b1;
            return ENTRY_MAX;
         end
         return mag[EW-1:0];
      end
      if (mag > emax + 1) begin
         clip = 1'b1;
         return ENTRY_MIN;
      end
      return EW'(-mag);
   endfunction

   function automatic void predict_inverse(input afi_req_type m);
      wide_int     a[3][4];
      wide_int     det;
      wide_int     cof;
      wide_int     tsum;
      wide_int     one;
      logic [EW-1:0] flat[12];
      afi_rsp_type row;
      logic        clip;
      flat = '{m.row0_col0, m.row0_col1, m.row0_col2, m.row0_col3,
               m.row1_col0, m.row1_col1, m.row1_col2, m.row1_col3,
               m.row2_col0, m.row2_col1, m.row2_col2, m.row2_col3};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            a[r][c] = wide_int'(signed'(flat[r*4+c]));
         end
      end
      det = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
          - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
          + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
      for (int r = 0; r < 3; r++) begin
         row = '0;
         clip = 1'b0;
         row.out_row = 2'(r);
         if (det == 0) begin
            // Singular input: identity rows, 1.0 saturating if it does not fit.
            one = wide_int'(1) <<< FB;
            row.singular = 1'b1;
            if (one > wide_int'(ENTRY_MAX)) begin
               one = wide_int'(ENTRY_MAX);
               clip = 1'b1;
            end
            if (r == 0) row.out_col0 = EW'(one);
            if (r == 1) row.out_col1 = EW'(one);
            if (r == 2) row.out_col2 = EW'(one);
         end else begin
            tsum = 0;
            for (int c = 0; c < 3; c++) begin
               cof = a[(c+1)%3][(r+1)%3] * a[(c+2)%3][(r+2)%3]
                   - a[(c+1)%3][(r+2)%3] * a[(c+2)%3][(r+1)%3];
               tsum += cof * a[c][3];
               case (c)
                  0: row.out_col0 = scaled_quotient(cof <<< (2*FB), det, clip);
                  1: row.out_col1 = scaled_quotient(cof <<< (2*FB), det, clip);
                  default: row.out_col2 = scaled_quotient(cof <<< (2*FB), det, clip);
               endcase
            end
            row.out_col3 = scaled_quotient(-(tsum <<< FB), det, clip);
         end
         row.clipped = clip;
         row.last_row = (r == 2);
         expected_rows.push_back(row);
      end
   endfunction

   function automatic void compare_field(input string name, input logic [EW-1:0] exp_v,
                                         input logic [EW-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      afi_rsp_type want;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) predict_inverse(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               $display("%0t: unexpected response row %0d", $time, rsp_data.out_row);
               fail_count++;
            end else begin
               want = expected_rows.pop_front();
               compare_field("out_row", EW'(want.out_row), EW'(rsp_data.out_row));
               compare_field("out_col0", want.out_col0, rsp_data.out_col0);
               compare_field("out_col1", want.out_col1, rsp_data.out_col1);
               compare_field("out_col2", want.out_col2, rsp_data.out_col2);
               compare_field("out_col3", want.out_col3, rsp_data.out_col3);
               compare_field("singular", EW'(want.singular), EW'(rsp_data.singular));
               compare_field("clipped", EW'(want.clipped), EW'(rsp_data.clipped));
               compare_field("last_row", EW'(want.last_row), EW'(rsp_data.last_row));
            end
         end
      end
   end

endmodule

>>> tb/sv/affine_matrix_inverse_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the affine matrix inverse: drives requests and response
// stalls, and gives the verdict. Depends on afi_pkg and afi_inverse_checker.
module affine_matrix_inverse_top_test;
   import afi_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ONE_Q = 1 << FB;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   afi_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   afi_rsp_type rsp_data;
   int          fail_count;
   int          rows_pending;
   int          cycle_count;

   // Idle percentages for the sender and the receiver, changed per phase.
   int          send_idle_pct;
   int          stall_pct;

   affine_matrix_inverse_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   afi_inverse_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .rows_pending(rows_pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL affine_matrix_inverse_top");
         $finish;
      end
   end

   // Present one request and hold it until accepted. Valid stays high into
   // the next request unless the sender decides to idle.
   task automatic send_matrix(input afi_req_type m);
      req_data  <= m;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   function automatic logic [EW-1:0] near_value(input int span);
      return EW'($signed($urandom_range(2 * span)) - span);
   endfunction

   // Matrices with entries of a few units: mostly regular, some singular,
   // some with fully random bits to reach saturation.
   function automatic afi_req_type random_matrix();
      afi_req_type m;
      int kind;
      kind = $urandom_range(99);
      if (kind < 15) begin
         m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         m.row0_col0 = near_value(4 * ONE_Q);
         m.row0_col1 = near_value(4 * ONE_Q);
         m.row0_col2 = near_value(4 * ONE_Q);
         m.row0_col3 = $urandom;
         m.row1_col0 = near_value(4 * ONE_Q);
         m.row1_col1 = near_value(4 * ONE_Q);
         m.row1_col2 = near_value(4 * ONE_Q);
         m.row1_col3 = near_value(1 << 24);
         m.row2_col0 = near_value(4 * ONE_Q);
         m.row2_col1 = near_value(4 * ONE_Q);
         m.row2_col2 = near_value(4 * ONE_Q);
         m.row2_col3 = near_value(1 << 24);
         if (kind < 27) begin
            // A repeated row makes the determinant zero.
            m.row2_col0 = m.row1_col0;
            m.row2_col1 = m.row1_col1;
            m.row2_col2 = m.row1_col2;
         end else if (kind < 35) begin
            // Tiny entries drive the inverse out of range.
            m.row0_col0 = near_value(3);
            m.row1_col1 = near_value(3);
            m.row2_col2 = near_value(3);
         end
      end
      return m;
   endfunction

   function automatic afi_req_type diagonal(input logic [EW-1:0] d0, input logic [EW-1:0] d1,
                                            input logic [EW-1:0] d2, input logic [EW-1:0] t);
      afi_req_type m;
      m = '0;
      m.row0_col0 = d0;
      m.row1_col1 = d1;
      m.row2_col2 = d2;
      m.row0_col3 = t;
      m.row1_col3 = -t;
      m.row2_col3 = t;
      return m;
   endfunction

   initial begin
      afi_req_type m;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      reset         = 1'b1;
      cycle_count   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: identity, zero and repeated-row singular cases,
      // extreme entries, scaling, a negative determinant and saturation.
      send_matrix(diagonal(ONE_Q, ONE_Q, ONE_Q, 0));
      send_matrix('0);
      send_matrix({12{ENTRY_MAX}});
      send_matrix({12{ENTRY_MIN}});
      send_matrix(diagonal(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
      send_matrix(diagonal(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
      send_matrix(diagonal(2 * ONE_Q, ONE_Q / 2, -ONE_Q, 3 * ONE_Q));
      send_matrix(diagonal(-ONE_Q, ONE_Q, ONE_Q, -(5 * ONE_Q)));
      send_matrix(diagonal(1, 1, 1, ENTRY_MAX));
      send_matrix(diagonal(-1, 1, 1, ENTRY_MIN));
      send_matrix(diagonal(ONE_Q, ONE_Q, 0, ONE_Q));
      send_matrix(diagonal(ENTRY_MAX, ENTRY_MIN, 1, 0));
      send_matrix({ENTRY_MAX, ENTRY_MIN, ENTRY_MAX, ENTRY_MIN,
                   ENTRY_MIN, ENTRY_MAX, ENTRY_MIN, ENTRY_MAX,
                   ENTRY_MAX, ENTRY_MAX, ENTRY_MIN, ENTRY_MIN});
      m = diagonal(ONE_Q, ONE_Q, ONE_Q, ONE_Q);
      m.row0_col1 = ONE_Q / 3;
      m.row1_col2 = -(ONE_Q / 7);
      m.row2_col0 = 5 * ONE_Q;
      send_matrix(m);

      // Random phases: free flow, sender gaps, receiver stalls, then both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 46; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 46; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         for (int n = 0; n < 54; n++) send_matrix(random_matrix());
      end
      req_valid <= 1'b0;

      // Drain outstanding rows, then give the pipeline time to show strays.
      while (rows_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS affine_matrix_inverse_top");
      end else begin
         $display("FAIL affine_matrix_inverse_top");
      end
      $finish;
   end

endmodule
